### rtl/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants for the sorted distinct identifier block.
// ----------------------------------------------------------------------------
package sdi_pkg;

    // identifier and reported count widths
    localparam int ID_W        = 64;
    localparam int CNT_OUT_W   = 6;
    localparam int MAX_IDS_DEF = 32;

    // controller state
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;   // take in the broadcast identifier
        logic shift;    // move every entry one place toward the head
    } t_cell_ctl;

endpackage

### rtl/sdi_cell.sv
// ----------------------------------------------------------------------------
// sdi_cell
// One slot of the insertion chain: holds one identifier, compares it with the
// broadcast identifier and moves data to or from its neighbors.
// ----------------------------------------------------------------------------
module sdi_cell (
    input  logic                        i_clk,
    input  sdi_pkg::t_cell_ctl          i_ctl,
    input  logic [sdi_pkg::ID_W-1:0]    i_id,
    input  logic                        i_valid,
    input  logic [sdi_pkg::ID_W-1:0]    i_left_val,
    input  logic                        i_left_lt,
    input  logic [sdi_pkg::ID_W-1:0]    i_right_val,
    output logic [sdi_pkg::ID_W-1:0]    o_val,
    output logic                        o_lt,
    output logic                        o_eq
);
    import sdi_pkg::*;

    logic [ID_W-1:0] r_val;
    logic [ID_W-1:0] n_val;

    // compare the held entry with the broadcast identifier
    assign o_lt  = i_valid && (r_val < i_id);
    assign o_eq  = i_valid && (r_val == i_id);
    assign o_val = r_val;

    // keep smaller entries, open a gap at the insertion point, push the rest on
    always_comb begin
        n_val = r_val;
        if (i_ctl.shift) begin
            n_val = i_right_val;
        end else if (i_ctl.insert && !o_lt) begin
            n_val = i_left_lt ? i_id : i_left_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### rtl/sort_distinct_ids_core.sv
// ----------------------------------------------------------------------------
// sort_distinct_ids_core
// Collects 64-bit identifiers into a sorted insertion chain, dropping zeros
// and repeats, and on the last item of a set streams the distinct ones out in
// ascending order.
//
//   channel   direction  handshake              payload
//   input     in         start / busy           i_object_id, i_last_in_set
//   result    out        o_result_valid strobe  o_distinct_id, o_last_of_run,
//                                               o_distinct_count, o_set_empty,
//                                               o_overflow_seen
//
// Loading takes one item per cycle: each cell compares in parallel and the
// chain opens a gap at the insertion point in the same cycle.
// After the last item the chain shifts toward the head once per cycle, and busy
// stays high until the last distinct identifier (or the empty-set result) has
// been drained; each result appears in the cycle after its drain step.
// Reset clears the count, overflow flag and controller; cells need no reset.
// The receiver cannot stall: every result strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module sort_distinct_ids_core #(
    parameter int MAX_IDS = sdi_pkg::MAX_IDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [sdi_pkg::ID_W-1:0]        i_object_id,
    input  logic                            i_last_in_set,
    output logic                            o_result_valid,
    output logic [sdi_pkg::ID_W-1:0]        o_distinct_id,
    output logic                            o_last_of_run,
    output logic [sdi_pkg::CNT_OUT_W-1:0]   o_distinct_count,
    output logic                            o_set_empty,
    output logic                            o_overflow_seen
);
    import sdi_pkg::*;

    localparam int CW = $clog2(MAX_IDS + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_ovf, n_ovf;

    logic            r_res_valid;
    logic [ID_W-1:0] r_res_id;
    logic            r_res_last;
    logic [CNT_OUT_W-1:0] r_res_cnt;
    logic            r_res_empty;
    logic            r_res_ovf;

    t_cell_ctl       cell_ctl;
    logic [ID_W-1:0] cell_val [MAX_IDS];
    logic [MAX_IDS-1:0] cell_lt;
    logic [MAX_IDS-1:0] cell_eq;

    logic accept, id_nz, dup, full, do_ins, ovf_set, drain_done, set_none;
    logic [6:0] count_ext;

    // input handshake and insert decision
    assign accept   = start && !busy;
    assign id_nz    = |i_object_id;
    assign dup      = |cell_eq;
    assign full     = (r_count == CW'(MAX_IDS));
    assign do_ins   = accept && id_nz && !dup && !full;
    assign ovf_set  = accept && id_nz && !dup && full;
    assign set_none = (r_count == '0);
    assign drain_done = (r_state == ST_DRAIN) && (set_none || (r_idx + 1'b1 == r_count));
    assign count_ext = 7'(r_count);

    // insertion chain
    for (genvar g = 0; g < MAX_IDS; g++) begin : g_cell
        logic [ID_W-1:0] left_val, right_val;
        logic            left_lt;
        if (g == 0) begin : g_head
            assign left_val = '0;
            assign left_lt  = 1'b1;
        end else begin : g_body
            assign left_val = cell_val[g-1];
            assign left_lt  = cell_lt[g-1];
        end
        if (g == MAX_IDS - 1) begin : g_tail
            assign right_val = cell_val[g];
        end else begin : g_mid
            assign right_val = cell_val[g+1];
        end

        sdi_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_id        (i_object_id),
            .i_valid     (CW'(g) < r_count),
            .i_left_val  (left_val),
            .i_left_lt   (left_lt),
            .i_right_val (right_val),
            .o_val       (cell_val[g]),
            .o_lt        (cell_lt[g]),
            .o_eq        (cell_eq[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (accept && i_last_in_set) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (drain_done) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // controller outputs
    always_comb begin
        busy           = 1'b0;
        cell_ctl       = '0;
        unique case (r_state)
            ST_LOAD: begin
                cell_ctl.insert = do_ins;
            end
            ST_DRAIN: begin
                busy           = 1'b1;
                cell_ctl.shift = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    // count, overflow flag and drain index
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_idx   = r_idx;
        if (drain_done) begin
            n_count = '0;
            n_ovf   = 1'b0;
            n_idx   = '0;
        end else if (r_state == ST_DRAIN) begin
            n_idx   = r_idx + 1'b1;
        end else begin
            if (do_ins)  n_count = r_count + 1'b1;
            if (ovf_set) n_ovf   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_res_valid <= (r_state == ST_DRAIN);
        end
    end

    // capture the head of the chain as the next item of the run
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DRAIN) begin
            r_res_id    <= set_none ? '0 : cell_val[0];
            r_res_last  <= drain_done;
            r_res_cnt   <= count_ext[CNT_OUT_W-1:0];
            r_res_empty <= set_none;
            r_res_ovf   <= r_ovf;
        end
    end

    assign o_result_valid   = r_res_valid;
    assign o_distinct_id    = r_res_id;
    assign o_last_of_run    = r_res_last;
    assign o_distinct_count = r_res_cnt;
    assign o_set_empty      = r_res_empty;
    assign o_overflow_seen  = r_res_ovf;

`ifndef ASSERT_OFF
    // a result only follows a drain step
    a_res_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_DRAIN))
        else $error("result strobe without drain step");

    // the chain never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_IDS))
        else $error("occupied count beyond depth");

    // overflow is raised only against a full chain
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> (r_count == CW'(MAX_IDS)))
        else $error("overflow raised while chain not full");

    // the empty-set result is always the end of its run
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_set_empty) |-> o_last_of_run)
        else $error("empty-set result not marked last");

    // no insert while the chain drains
    a_no_ins_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !cell_ctl.insert)
        else $error("insert during drain");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sort_distinct_ids_core. A short table of directed
// sets covers the empty set, extreme identifiers, zeros and repeats; random
// sets follow: mixed small sets, a full store with repeats, overflowing
// stores and all-zero sets, under several sender idling mixes. A
// behavioral copy of the sorted store predicts each unpinned result, and
// each strobed result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdi_pkg::*;

    localparam int DEPTH      = MAX_IDS_DEF;
    localparam int RAND_ITEMS = 245;

    typedef logic [ID_W-1:0] t_id;

    typedef struct packed {
        t_id                  id;
        logic                 last;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty;
        logic                 ovf;
    } t_run_result;

    typedef struct packed {
        t_id         id;
        logic        last;
        logic        pinned;   // use the typed-in result instead of the predictor
        t_run_result want;
    } t_stim_row;

    localparam t_id         ID_MAX = '1;
    localparam t_run_result NO_PIN = '0;

    // directed sets; only the obvious single-result cases carry a typed result
    localparam int DIR_ROWS = 18;
    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        // empty set straight after reset
        '{'0, 1'b1, 1'b1, '{'0, 1'b1, 6'd0, 1'b1, 1'b0}},
        // largest identifier alone
        '{ID_MAX, 1'b1, 1'b1, '{ID_MAX, 1'b1, 6'd1, 1'b0, 1'b0}},
        // smallest nonzero identifier alone
        '{64'd1, 1'b1, 1'b1, '{64'd1, 1'b1, 6'd1, 1'b0, 1'b0}},
        // extremes, zeros and repeats mixed in one set
        '{64'h8000_0000_0000_0000, 1'b0, 1'b0, NO_PIN},
        '{64'd5, 1'b0, 1'b0, NO_PIN},
        '{'0, 1'b0, 1'b0, NO_PIN},
        '{64'd5, 1'b0, 1'b0, NO_PIN},
        '{ID_MAX, 1'b0, 1'b0, NO_PIN},
        '{64'd1, 1'b0, 1'b0, NO_PIN},
        '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_PIN},
        '{64'd5, 1'b1, 1'b0, NO_PIN},
        // set made of zeros only
        '{'0, 1'b0, 1'b0, NO_PIN},
        '{'0, 1'b1, 1'b1, '{'0, 1'b1, 6'd0, 1'b1, 1'b0}},
        // repeat collapses to one entry
        '{64'd9, 1'b0, 1'b0, NO_PIN},
        '{64'd9, 1'b1, 1'b1, '{64'd9, 1'b1, 6'd1, 1'b0, 1'b0}},
        // descending arrival, set closed by a zero
        '{64'd3, 1'b0, 1'b0, NO_PIN},
        '{64'd2, 1'b0, 1'b0, NO_PIN},
        '{'0, 1'b1, 1'b0, NO_PIN}
    };

    // set kinds of the random part
    typedef enum int {
        SET_MIXED,
        SET_FULL_REPEAT,
        SET_OVERFLOW,
        SET_ZEROS
    } t_set_kind;

    // sender idle percentage per phase; the receiver-stall phase cannot apply
    localparam int IDLE_PCT [4] = '{0, 49, 0, 28};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_id                  i_object_id;
    logic                 i_last_in_set;
    logic                 o_result_valid;
    t_id                  o_distinct_id;
    logic                 o_last_of_run;
    logic [CNT_OUT_W-1:0] o_distinct_count;
    logic                 o_set_empty;
    logic                 o_overflow_seen;

    // typed-in result travelling with the item on offer
    logic        pin_valid;
    t_run_result pin_want;

    // predictor state and pending results
    t_id         held_ids[$];
    logic        held_ovf = 1'b0;
    t_run_result pending_runs[$];
    int          errors = 0;
    int          sent_items = 0;

    sort_distinct_ids_core #(
        .MAX_IDS(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_object_id     (i_object_id),
        .i_last_in_set   (i_last_in_set),
        .o_result_valid  (o_result_valid),
        .o_distinct_id   (o_distinct_id),
        .o_last_of_run   (o_last_of_run),
        .o_distinct_count(o_distinct_count),
        .o_set_empty     (o_set_empty),
        .o_overflow_seen (o_overflow_seen)
    );

    always #5 i_clk = ~i_clk;

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // take one identifier into the sorted set; on the last item queue the run
    function automatic void absorb_id(input t_id id, input logic last,
                                      input logic pinned, input t_run_result want);
        int          pos;
        int          n;
        t_run_result r;
        pos = 0;
        if (id != '0) begin
            while (pos < held_ids.size() && held_ids[pos] < id)
                pos++;
            if (pos >= held_ids.size() || held_ids[pos] != id) begin
                if (held_ids.size() >= DEPTH)
                    held_ovf = 1'b1;
                else
                    held_ids.insert(pos, id);
            end
        end
        if (!last)
            return;
        n = held_ids.size();
        if (pinned) begin
            pending_runs.push_back(want);
        end else if (n == 0) begin
            r = '0;
            r.last  = 1'b1;
            r.empty = 1'b1;
            r.ovf   = held_ovf;
            pending_runs.push_back(r);
        end else begin
            for (int k = 0; k < n; k++) begin
                r.id    = held_ids[k];
                r.last  = (k == n - 1);
                r.count = n[CNT_OUT_W-1:0];
                r.empty = 1'b0;
                r.ovf   = held_ovf;
                pending_runs.push_back(r);
            end
        end
        held_ids.delete();
        held_ovf = 1'b0;
    endfunction

    // check strobed results first, then record the item accepted at this edge
    always @(posedge i_clk) begin
        t_run_result want;
        if (i_rst_n) begin
            if ($isunknown(o_result_valid)) begin
                log_error("result strobe unknown");
            end else if (o_result_valid) begin
                if (pending_runs.size() == 0) begin
                    log_error($sformatf("unexpected result id=%h", o_distinct_id));
                end else begin
                    want = pending_runs.pop_front();
                    if (o_distinct_id !== want.id)
                        log_error($sformatf("distinct_id %h, want %h",
                                            o_distinct_id, want.id));
                    if (o_last_of_run !== want.last)
                        log_error($sformatf("last_of_run %b, want %b (id %h)",
                                            o_last_of_run, want.last, want.id));
                    if (o_distinct_count !== want.count)
                        log_error($sformatf("distinct_count %0d, want %0d (id %h)",
                                            o_distinct_count, want.count, want.id));
                    if (o_set_empty !== want.empty)
                        log_error($sformatf("set_empty %b, want %b (id %h)",
                                            o_set_empty, want.empty, want.id));
                    if (o_overflow_seen !== want.ovf)
                        log_error($sformatf("overflow_seen %b, want %b (id %h)",
                                            o_overflow_seen, want.ovf, want.id));
                end
            end
            if (start && !busy)
                absorb_id(i_object_id, i_last_in_set, pin_valid, pin_want);
        end
    end

    // offer one item, idling first at random, and hold it until accepted
    task automatic offer(input t_id id, input logic last, input int idle_pct,
                         input logic pinned, input t_run_result want);
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_object_id   <= id;
        i_last_in_set <= last;
        pin_valid     <= pinned;
        pin_want      <= want;
        do @(posedge i_clk); while (busy !== 1'b0);
        sent_items++;
    endtask

    // hold the sender off until every pending result has come out
    task automatic hold_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_runs.size() != 0);
    endtask

    function automatic t_id random_nonzero();
        t_id v;
        v = {$urandom, $urandom};
        return (v == '0) ? t_id'(1) : v;
    endfunction

    // build one random set of the given kind and send it
    task automatic play_set(input t_set_kind kind, input int idle_pct);
        t_id ids[$];
        t_id v;
        int  n;
        case (kind)
            SET_MIXED: begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 9))
                        0: v = '0;
                        1: v = (ids.size() > 0) ? ids[$urandom_range(0, ids.size() - 1)]
                                                : random_nonzero();
                        2, 3: v = t_id'($urandom_range(1, 40));
                        4: v = t_id'(1) << $urandom_range(0, ID_W - 1);
                        5: v = ~(t_id'(1) << $urandom_range(0, ID_W - 1));
                        default: v = random_nonzero();
                    endcase
                    ids.push_back(v);
                end
            end
            SET_FULL_REPEAT: begin
                // fill the store exactly, then offer held ones again
                for (int i = 0; i < DEPTH; i++)
                    ids.push_back(random_nonzero());
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    ids.push_back(ids[$urandom_range(0, DEPTH - 1)]);
            end
            SET_OVERFLOW: begin
                n = $urandom_range(DEPTH + 1, DEPTH + 8);
                for (int i = 0; i < n; i++)
                    ids.push_back(random_nonzero());
            end
            default: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    ids.push_back('0);
            end
        endcase
        foreach (ids[i])
            offer(ids[i], i == ids.size() - 1, idle_pct, 1'b0, NO_PIN);
    endtask

    // main sequence
    initial begin
        int        sets;
        int        phase;
        t_set_kind kind;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_object_id   <= '0;
        i_last_in_set <= 1'b0;
        pin_valid     <= 1'b0;
        pin_want      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table back to back
        foreach (DIR_TABLE[r])
            offer(DIR_TABLE[r].id, DIR_TABLE[r].last, 0,
                  DIR_TABLE[r].pinned, DIR_TABLE[r].want);

        // random sets; switch idling phase every six sets after a full drain
        sets = 0;
        while (sent_items < DIR_ROWS + RAND_ITEMS) begin
            phase = (sets / 6) % 4;
            if (sets > 0 && sets % 6 == 0)
                hold_until_drained();
            if (sets == 0)
                kind = SET_FULL_REPEAT;
            else if (sets == 1)
                kind = SET_OVERFLOW;
            else begin
                case ($urandom_range(0, 9))
                    6: kind = SET_FULL_REPEAT;
                    7: kind = SET_OVERFLOW;
                    8: kind = SET_ZEROS;
                    default: kind = SET_MIXED;
                endcase
            end
            play_set(kind, IDLE_PCT[phase]);
            sets++;
        end
        start <= 1'b0;

        // let the last run come out, then a little longer
        for (int i = 0; i < 20 * DEPTH && pending_runs.size() != 0; i++)
            @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (pending_runs.size() != 0)
            log_error($sformatf("%0d results never arrived", pending_runs.size()));

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // stop a hung run
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/sdi_pkg.sv
rtl/sdi_cell.sv
rtl/sort_distinct_ids_core.sv
tb/tb_top.sv
